// File: sv/tapsl_pkg.sv
// Shared types, codes and field helpers for the triangle plane slicer.
// Used by tapsl_mdu, tapsl_seq and the top level; depends on nothing.
package tapsl_pkg;

    localparam int POS_W  = 32;
    localparam int COL_W  = 16;
    localparam int ACC_W  = 66;
    localparam int QUO_W  = 33;
    localparam int OPA_W  = 33;
    localparam int OPB_W  = 32;
    localparam int STEP_W = 6;
    localparam int OIDX_W = 24;

    localparam logic [STEP_W-1:0] STEPS_POS = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_COL = 6'd16;
    localparam logic [STEP_W-1:0] STEPS_DIV = 6'd33;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // edge codes, in emission order
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_AC = 2'd1;
    localparam logic [1:0] EDGE_BC = 2'd2;

    // register indexes
    localparam logic REG_PLANE_AXIS = 1'b0;
    localparam logic REG_PLANE_POS  = 1'b1;

    // per-point jobs: two positions, then four colour channels
    localparam logic [2:0] JOB_O1 = 3'd0;
    localparam logic [2:0] JOB_O2 = 3'd1;
    localparam logic [2:0] JOB_R  = 3'd2;
    localparam logic [2:0] JOB_A  = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [COL_W-1:0] cr;
        logic [COL_W-1:0] cg;
        logic [COL_W-1:0] cb;
        logic [COL_W-1:0] ca;
    } t_vtx;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MAC  = 2'd1,
        OP_DIV  = 2'd2
    } t_mdu_op;

    typedef struct packed {
        logic              start;
        t_mdu_op           op;
        logic [OPA_W-1:0]  opa;
        logic [OPB_W-1:0]  opb;
        logic [STEP_W-1:0] nbits;
    } t_mdu_req;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quo;
    } t_mdu_rsp;

    function automatic logic [POS_W-1:0] pos_of(input t_vtx v, input logic [1:0] a);
        logic [POS_W-1:0] r;
        case (a)
            AXIS_X: r = v.px;
            AXIS_Y: r = v.py;
            default: r = v.pz;
        endcase
        return r;
    endfunction

    function automatic t_vtx set_pos(input t_vtx v, input logic [1:0] a,
                                     input logic [POS_W-1:0] p);
        t_vtx r;
        r = v;
        case (a)
            AXIS_X: r.px = p;
            AXIS_Y: r.py = p;
            default: r.pz = p;
        endcase
        return r;
    endfunction

    function automatic logic [COL_W-1:0] col_of(input t_vtx v, input logic [1:0] ch);
        logic [COL_W-1:0] r;
        case (ch)
            2'd0: r = v.cr;
            2'd1: r = v.cg;
            2'd2: r = v.cb;
            default: r = v.ca;
        endcase
        return r;
    endfunction

    function automatic t_vtx set_col(input t_vtx v, input logic [1:0] ch,
                                     input logic [COL_W-1:0] c);
        t_vtx r;
        r = v;
        case (ch)
            2'd0: r.cr = c;
            2'd1: r.cg = c;
            2'd2: r.cb = c;
            default: r.ca = c;
        endcase
        return r;
    endfunction

endpackage

// File: sv/tapsl_mdu.sv
// Bit-serial multiply-accumulate and restoring divide unit.
// Depends on tapsl_pkg for the request and response structs.
module tapsl_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tapsl_pkg::t_mdu_req i_req,
    output tapsl_pkg::t_mdu_rsp o_rsp
);
    import tapsl_pkg::*;

    logic              r_busy, n_busy;
    t_mdu_op           r_op, n_op;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_a, n_a;
    logic [OPB_W-1:0]  r_b, n_b;
    logic [OPA_W-1:0]  r_div, n_div;
    logic [OPA_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [OPA_W:0]    w_trial;
    logic [OPA_W:0]    w_diff;

    // one step per cycle: add-and-shift or compare-and-subtract
    always_comb begin
        n_busy  = r_busy;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_trial = {r_rem, r_acc[ACC_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (r_busy) begin
            case (r_op)
                OP_MAC: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = {r_a[ACC_W-2:0], 1'b0};
                    n_b = {1'b0, r_b[OPB_W-1:1]};
                end
                default: begin
                    n_acc = {r_acc[ACC_W-2:0], 1'b0};
                    if (!w_diff[OPA_W]) begin
                        n_rem = w_diff[OPA_W-1:0];
                        n_quo = {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_trial[OPA_W-1:0];
                        n_quo = {r_quo[QUO_W-2:0], 1'b0};
                    end
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end else if (i_req.start) begin
            case (i_req.op)
                OP_LOAD: begin
                    n_acc = ACC_W'(i_req.opa);
                end
                OP_MAC: begin
                    n_op   = OP_MAC;
                    n_a    = ACC_W'(i_req.opa);
                    n_b    = i_req.opb;
                    n_cnt  = i_req.nbits;
                    n_busy = 1'b1;
                end
                default: begin
                    // quotient fits QUO_W bits, so the top part is already below the divisor
                    n_op   = OP_DIV;
                    n_rem  = r_acc[ACC_W-1:ACC_W-OPA_W];
                    n_acc  = {r_acc[ACC_W-OPA_W-1:0], {OPA_W{1'b0}}};
                    n_div  = i_req.opa;
                    n_quo  = '0;
                    n_cnt  = STEPS_DIV;
                    n_busy = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= OP_LOAD;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;

    // a started long operation always runs
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_req.start && (i_req.op == OP_MAC || i_req.op == OP_DIV))
        |=> r_busy) else $error("mdu did not start");
    // divider remainder stays below divisor
    a_rem_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == OP_DIV) |-> (r_rem < r_div)) else $error("remainder overflow");
    // step count never runs out while busy
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("busy with zero count");

endmodule

// File: sv/tapsl_seq.sv
// Sequencer: vertex hold, plane distances, edge walk and output register.
// Depends on tapsl_pkg; drives the shared tapsl_mdu through a request struct.
module tapsl_seq #(
    parameter int INDEX_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tapsl_pkg::t_vtx     i_vtx,
    input  logic [1:0]          i_plane_axis,
    input  logic [31:0]         i_plane_position,
    output tapsl_pkg::t_mdu_req o_req,
    input  tapsl_pkg::t_mdu_rsp i_rsp,
    output logic                o_valid,
    input  logic                i_stall,
    output tapsl_pkg::t_vtx     o_vtx,
    output logic [23:0]         o_point_index,
    output logic                o_last,
    output logic                o_outline_triangle
);
    import tapsl_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_EVAL   = 14'b00000000000010,
        S_CLASS  = 14'b00000000000100,
        S_EDGE   = 14'b00000000001000,
        S_JLOAD  = 14'b00000000010000,
        S_JMAC1  = 14'b00000000100000,
        S_JW1    = 14'b00000001000000,
        S_JMAC2  = 14'b00000010000000,
        S_JW2    = 14'b00000100000000,
        S_JDIV   = 14'b00001000000000,
        S_JW3    = 14'b00010000000000,
        S_JSTORE = 14'b00100000000000,
        S_CP     = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]            r_slot;
    t_vtx                  r_v0, r_v1, r_v2;
    logic signed [32:0]    r_d0, r_d1, r_d2;
    logic [2:0]            r_cross;
    logic [1:0]            r_left;
    logic [1:0]            r_k;
    logic                  r_cp;
    logic                  r_outline;
    t_vtx                  r_pa, r_pb, r_wrk;
    logic [32:0]           r_ma, r_mb, r_norm;
    logic [2:0]            r_job;
    logic [32:0]           r_mc1, r_mc2;
    logic [31:0]           r_mp1, r_mp2;
    logic [STEP_W-1:0]     r_nb;
    logic                  r_two;
    logic                  r_neg;
    logic [INDEX_BITS-1:0] r_cnt;
    logic                  r_ovalid;
    t_vtx                  r_out;
    logic                  r_olast;
    logic                  r_ooutline;
    logic [INDEX_BITS-1:0] r_oidx;

    logic [1:0]         w_ax, w_o1, w_o2, w_o, w_ch;
    t_vtx               w_va, w_vb, w_vk;
    logic signed [32:0] w_da, w_db;
    logic [32:0]        w_ma, w_mb;
    logic [2:0]         w_cross;
    logic [1:0]         w_ncross;
    logic               w_allzero;
    logic [31:0]        w_pa_o, w_pb_o;
    logic [32:0]        w_diff, w_adiff;
    logic [33:0]        w_sum;
    logic [15:0]        w_col;
    logic               w_out_free;
    logic [31:0]        w_idx32;
    logic [31:0]        w_p0, w_p1, w_p2;

    function automatic logic crosses(input logic signed [32:0] x, input logic signed [32:0] y);
        logic xp, yp;
        xp = !x[32] && (x != '0);
        yp = !y[32] && (y != '0);
        return (xp != yp) || (x[32] != y[32]);
    endfunction

    // effective axis, code three acts as z
    always_comb begin
        w_ax = (i_plane_axis == 2'd3) ? AXIS_Z : i_plane_axis;
        w_o1 = (w_ax == AXIS_X) ? AXIS_Y : AXIS_X;
        w_o2 = (w_ax == AXIS_Z) ? AXIS_Y : AXIS_Z;
    end

    // vertex coordinates along the plane axis
    assign w_p0 = pos_of(r_v0, w_ax);
    assign w_p1 = pos_of(r_v1, w_ax);
    assign w_p2 = pos_of(r_v2, w_ax);

    // edge endpoints and distance magnitudes
    always_comb begin
        w_va = (r_k == EDGE_BC) ? r_v1 : r_v0;
        w_vb = (r_k == EDGE_AB) ? r_v1 : r_v2;
        w_da = (r_k == EDGE_BC) ? r_d1 : r_d0;
        w_db = (r_k == EDGE_AB) ? r_d1 : r_d2;
        w_ma = w_da[32] ? 33'(-w_da) : 33'(w_da);
        w_mb = w_db[32] ? 33'(-w_db) : 33'(w_db);
        case (r_k)
            EDGE_AB: w_vk = r_v0;
            EDGE_AC: w_vk = r_v1;
            default: w_vk = r_v2;
        endcase
    end

    // classify the triangle
    always_comb begin
        w_cross   = {crosses(r_d1, r_d2), crosses(r_d0, r_d2), crosses(r_d0, r_d1)};
        w_ncross  = 2'(w_cross[0]) + 2'(w_cross[1]) + 2'(w_cross[2]);
        w_allzero = (r_d0 == '0) && (r_d1 == '0) && (r_d2 == '0);
    end

    // job operands and result write-back
    always_comb begin
        w_o     = (r_job == JOB_O1) ? w_o1 : w_o2;
        w_ch    = 2'(r_job - JOB_R);
        w_pa_o  = pos_of(r_pa, w_o);
        w_pb_o  = pos_of(r_pb, w_o);
        w_diff  = {w_pb_o[31], w_pb_o} - {w_pa_o[31], w_pa_o};
        w_adiff = w_diff[32] ? 33'(-w_diff) : w_diff;
        w_sum   = r_neg ? ({{2{w_pa_o[31]}}, w_pa_o} - {1'b0, i_rsp.quo})
                        : ({{2{w_pa_o[31]}}, w_pa_o} + {1'b0, i_rsp.quo});
        w_col   = (i_rsp.quo[32:16] != '0) ? 16'hFFFF : i_rsp.quo[15:0];
    end

    assign w_out_free = !r_ovalid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_slot == 2'd2) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: n_state = S_CLASS;
            S_CLASS: begin
                if (w_allzero) begin
                    n_state = S_CP;
                end else if (w_ncross < 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (r_cross[r_k]) begin
                    n_state = S_JLOAD;
                end
            end
            S_JLOAD: n_state = S_JMAC1;
            S_JMAC1: n_state = S_JW1;
            S_JW1: begin
                if (!i_rsp.busy) begin
                    n_state = r_two ? S_JMAC2 : S_JDIV;
                end
            end
            S_JMAC2: n_state = S_JW2;
            S_JW2: begin
                if (!i_rsp.busy) begin
                    n_state = S_JDIV;
                end
            end
            S_JDIV: n_state = S_JW3;
            S_JW3: begin
                if (!i_rsp.busy) begin
                    n_state = S_JSTORE;
                end
            end
            S_JSTORE: n_state = (r_job == JOB_A) ? S_OUT : S_JLOAD;
            S_CP: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    if (r_left == 2'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = r_cp ? S_CP : S_EDGE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // requests to the shared unit
    always_comb begin
        o_req       = '0;
        o_req.op    = OP_LOAD;
        case (r_state)
            S_JLOAD: begin
                o_req.start = 1'b1;
                o_req.op    = OP_LOAD;
                o_req.opa   = {1'b0, r_norm[32:1]};
            end
            S_JMAC1: begin
                o_req.start = 1'b1;
                o_req.op    = OP_MAC;
                o_req.opa   = r_mc1;
                o_req.opb   = r_mp1;
                o_req.nbits = r_nb;
            end
            S_JMAC2: begin
                o_req.start = 1'b1;
                o_req.op    = OP_MAC;
                o_req.opa   = r_mc2;
                o_req.opb   = r_mp2;
                o_req.nbits = r_nb;
            end
            S_JDIV: begin
                o_req.start = 1'b1;
                o_req.op    = OP_DIV;
                o_req.opa   = r_norm;
            end
            default: o_req.start = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_left   <= '0;
            r_k      <= EDGE_AB;
            r_job    <= JOB_O1;
            r_cp     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid) begin
                r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
            end
            // load a new point item, or drop the one taken downstream
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLASS: begin
                    r_k  <= EDGE_AB;
                    r_cp <= w_allzero;
                    r_left <= w_allzero ? 2'd3 : w_ncross;
                end
                S_EDGE: begin
                    if (r_cross[r_k]) begin
                        r_job <= JOB_O1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_JSTORE: r_job <= r_job + 3'd1;
                S_OUT: begin
                    if (w_out_free) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_left   <= r_left - 2'd1;
                        r_k      <= r_k + 2'd1;
                    end
                end
                default: r_k <= r_k;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            case (r_slot)
                2'd0: r_v0 <= i_vtx;
                2'd1: r_v1 <= i_vtx;
                default: r_v2 <= i_vtx;
            endcase
        end
        case (r_state)
            S_EVAL: begin
                r_d0 <= $signed({i_plane_position[31], i_plane_position})
                      - $signed({w_p0[31], w_p0});
                r_d1 <= $signed({i_plane_position[31], i_plane_position})
                      - $signed({w_p1[31], w_p1});
                r_d2 <= $signed({i_plane_position[31], i_plane_position})
                      - $signed({w_p2[31], w_p2});
            end
            S_CLASS: begin
                r_cross   <= w_cross;
                r_outline <= w_allzero || (w_ncross == 2'd3);
            end
            S_EDGE: begin
                r_pa   <= w_va;
                r_pb   <= w_vb;
                r_ma   <= w_ma;
                r_mb   <= w_mb;
                r_norm <= w_ma + w_mb;
                r_wrk  <= set_pos(w_va, w_ax, i_plane_position);
            end
            S_JLOAD: begin
                if (r_job < JOB_R) begin
                    r_mc1 <= r_ma;
                    r_mp1 <= w_adiff[31:0];
                    r_neg <= w_diff[32];
                    r_nb  <= STEPS_POS;
                    r_two <= 1'b0;
                end else begin
                    r_mc1 <= r_mb;
                    r_mp1 <= 32'(col_of(r_pa, w_ch));
                    r_mc2 <= r_ma;
                    r_mp2 <= 32'(col_of(r_pb, w_ch));
                    r_nb  <= STEPS_COL;
                    r_two <= 1'b1;
                end
            end
            S_JSTORE: begin
                if (r_job < JOB_R) begin
                    r_wrk <= set_pos(r_wrk, w_o, w_sum[31:0]);
                end else begin
                    r_wrk <= set_col(r_wrk, w_ch, w_col);
                end
            end
            S_CP: r_wrk <= w_vk;
            S_OUT: begin
                if (w_out_free) begin
                    r_out      <= r_wrk;
                    r_olast    <= (r_left == 2'd1);
                    r_ooutline <= r_outline;
                    r_oidx     <= r_cnt;
                end
            end
            default: r_norm <= r_norm;
        endcase
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_ovalid;
    assign o_vtx              = r_out;
    assign o_last             = r_olast;
    assign o_outline_triangle = r_ooutline;
    assign w_idx32            = 32'(r_oidx);
    assign o_point_index      = w_idx32[OIDX_W-1:0];

    // a crossing edge never has a zero norm
    a_norm_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JLOAD) |-> (r_norm != '0)) else $error("zero norm on crossing edge");
    // emitting with no points left means the count went wrong
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_left != 2'd0)) else $error("emit with no points left");
    // colour quotient never exceeds full scale
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JSTORE && r_job >= JOB_R) |-> (i_rsp.quo[32:16] == '0))
        else $error("colour quotient out of range");
    // a multiply request keeps the unit busy next cycle
    a_mac_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JMAC1) |=> i_rsp.busy) else $error("shared unit idle after request");
    // point counter advances once per emitted item
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_cnt == INDEX_BITS'($past(r_cnt) + 1'b1)))
        else $error("point counter slip");

endmodule

// File: sv/triangle_axis_plane_slicer_top.sv
// Top level of the triangle plane slicer: APB registers and module wiring.
// Depends on tapsl_pkg, tapsl_mdu and tapsl_seq.
//
//  channel   direction  handshake            payload
//  vertex    in         i_valid / o_stall    i_pos_x..z, i_col_r..a
//  point     out        o_valid / i_stall    o_out_x..z, o_out_r..a, o_point_index,
//                                            o_last, o_outline_triangle
//  config    in         APB psel/penable     paddr, pwdata, prdata
//
// The first two vertices of a triangle are held. The third is classified in
// S_EVAL and S_CLASS; S_EDGE then passes over each edge without a crossing, and
// each crossing edge runs six jobs on the bit-serial multiply/divide unit (a
// 32-step multiply or two 16-step multiplies, then a 33-step divide). An
// all-on-plane triangle goes through S_CP and S_OUT per point. No input item is
// taken while a triangle is in work. Synchronous active-low reset; no clearing pass.
// A stalled point holds in the output register while the next vertices are taken.
module triangle_axis_plane_slicer_top #(
    parameter int INDEX_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [15:0] i_col_r,
    input  logic [15:0] i_col_g,
    input  logic [15:0] i_col_b,
    input  logic [15:0] i_col_a,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [15:0] o_out_r,
    output logic [15:0] o_out_g,
    output logic [15:0] o_out_b,
    output logic [15:0] o_out_a,
    output logic [23:0] o_point_index,
    output logic        o_last,
    output logic        o_outline_triangle,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tapsl_pkg::*;

    logic [1:0]  r_plane_axis;
    logic [31:0] r_plane_position;
    t_vtx        w_in_vtx, w_out_vtx;
    t_mdu_req    w_req;
    t_mdu_rsp    w_rsp;
    logic        w_wr;

    // register writes
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_axis     <= AXIS_X;
            r_plane_position <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PLANE_AXIS: r_plane_axis     <= pwdata[1:0];
                default:        r_plane_position <= pwdata;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            REG_PLANE_AXIS: prdata = {30'd0, r_plane_axis};
            default:        prdata = r_plane_position;
        endcase
    end

    assign pready = 1'b1;

    assign w_in_vtx = '{px: i_pos_x, py: i_pos_y, pz: i_pos_z,
                        cr: i_col_r, cg: i_col_g, cb: i_col_b, ca: i_col_a};

    tapsl_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    tapsl_seq #(
        .INDEX_BITS (INDEX_BITS)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_vtx              (w_in_vtx),
        .i_plane_axis       (r_plane_axis),
        .i_plane_position   (r_plane_position),
        .o_req              (w_req),
        .i_rsp              (w_rsp),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_vtx              (w_out_vtx),
        .o_point_index      (o_point_index),
        .o_last             (o_last),
        .o_outline_triangle (o_outline_triangle)
    );

    assign o_out_x = w_out_vtx.px;
    assign o_out_y = w_out_vtx.py;
    assign o_out_z = w_out_vtx.pz;
    assign o_out_r = w_out_vtx.cr;
    assign o_out_g = w_out_vtx.cg;
    assign o_out_b = w_out_vtx.cb;
    assign o_out_a = w_out_vtx.ca;

endmodule

// File: tb/triangle_axis_plane_slicer_top_tb.sv
// Testbench for the triangle plane slicer: drives vertex items and APB writes,
// predicts crossing points in a behavioral slicer and checks every point item.
// Depends on tapsl_pkg and triangle_axis_plane_slicer_top.
`timescale 1ns / 1ps
module triangle_axis_plane_slicer_top_tb;
    import tapsl_pkg::*;

    typedef struct {
        logic [31:0] x, y, z;
        logic [15:0] r, g, b, a;
        logic [23:0] idx;
        logic        lst, outl;
    } point_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [15:0] i_col_r = '0, i_col_g = '0, i_col_b = '0, i_col_a = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_out_x, o_out_y, o_out_z;
    logic [15:0] o_out_r, o_out_g, o_out_b, o_out_a;
    logic [23:0] o_point_index;
    logic        o_last, o_outline_triangle;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    triangle_axis_plane_slicer_top dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [1:0]        cur_axis = AXIS_X;
    logic signed [31:0] cur_plane = '0;
    t_vtx              held_vtx [2];
    int                slot_cnt = 0;
    logic [23:0]       point_cnt = '0;
    point_t            pending_points [$];
    int                err_cnt = 0;

    // idle controls: percent of cycles idle
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;

    function automatic logic signed [63:0] axis_val(t_vtx v, int ax);
        return ax == 0 ? 64'($signed(v.px)) : ax == 1 ? 64'($signed(v.py))
                                                      : 64'($signed(v.pz));
    endfunction

    function automatic logic [31:0] blend_pos(logic signed [63:0] pa, logic signed [63:0] pb,
                                              logic [63:0] ma, logic [63:0] norm);
        logic signed [63:0] diff;
        logic [63:0] q, md;
        diff = pb - pa;
        md = diff < 0 ? -diff : diff;
        q = (ma * md + norm / 2) / norm;
        return 32'(diff >= 0 ? pa + q : pa - q);
    endfunction

    function automatic logic [15:0] blend_col(logic [15:0] ca, logic [15:0] cb,
                                              logic [63:0] ma, logic [63:0] mb);
        logic [63:0] s, v;
        s = ca * mb + cb * ma;
        v = (s + (ma + mb) / 2) / (ma + mb);
        return v > 64'hFFFF ? 16'hFFFF : v[15:0];
    endfunction

    // slice one completed triangle, queue its points
    task automatic slice_triangle(t_vtx v2);
        t_vtx p [3];
        logic signed [63:0] d [3];
        t_vtx pts [3];
        int ea [3] = '{0, 0, 1};
        int eb [3] = '{1, 2, 2};
        int n, ax, o1, o2, a, b;
        logic [63:0] ma, mb;
        point_t pt;
        p[0] = held_vtx[0]; p[1] = held_vtx[1]; p[2] = v2;
        ax = cur_axis == 2'd3 ? 2 : cur_axis;
        o1 = ax == 0 ? 1 : 0;
        o2 = ax == 2 ? 1 : 2;
        n = 0;
        for (int i = 0; i < 3; i++) d[i] = cur_plane - axis_val(p[i], ax);
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            pts = p;
            n = 3;
        end else begin
            for (int k = 0; k < 3; k++) begin
                logic [31:0] c [3];
                a = ea[k]; b = eb[k];
                if (((d[a] > 0) == (d[b] > 0)) && ((d[a] < 0) == (d[b] < 0))) continue;
                ma = d[a] < 0 ? -d[a] : d[a];
                mb = d[b] < 0 ? -d[b] : d[b];
                c[ax] = cur_plane;
                c[o1] = blend_pos(axis_val(p[a], o1), axis_val(p[b], o1), ma, ma + mb);
                c[o2] = blend_pos(axis_val(p[a], o2), axis_val(p[b], o2), ma, ma + mb);
                pts[n].px = c[0]; pts[n].py = c[1]; pts[n].pz = c[2];
                pts[n].cr = blend_col(p[a].cr, p[b].cr, ma, mb);
                pts[n].cg = blend_col(p[a].cg, p[b].cg, ma, mb);
                pts[n].cb = blend_col(p[a].cb, p[b].cb, ma, mb);
                pts[n].ca = blend_col(p[a].ca, p[b].ca, ma, mb);
                n++;
            end
        end
        if (n < 2) return;
        for (int k = 0; k < n; k++) begin
            pt.x = pts[k].px; pt.y = pts[k].py; pt.z = pts[k].pz;
            pt.r = pts[k].cr; pt.g = pts[k].cg; pt.b = pts[k].cb; pt.a = pts[k].ca;
            pt.idx = point_cnt;
            pt.lst = (k == n - 1);
            pt.outl = (n == 3);
            pending_points.insert(pending_points.size(), pt);
            point_cnt++;
        end
    endtask

    // send one vertex item and predict on acceptance; valid stays up after
    // acceptance until the next item or an idle stretch replaces it
    task automatic send_vertex(t_vtx v);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= v.px; i_pos_y <= v.py; i_pos_z <= v.pz;
        i_col_r <= v.cr; i_col_g <= v.cg; i_col_b <= v.cb; i_col_a <= v.ca;
        do @(posedge i_clk); while (o_stall);
        if (slot_cnt < 2) begin
            held_vtx[slot_cnt] = v;
            slot_cnt++;
        end else begin
            slot_cnt = 0;
            slice_triangle(v);
        end
    endtask

    // one APB write, returning to idle before the next transfer
    task automatic apb_write(logic regsel, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {regsel, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        if (regsel == REG_PLANE_AXIS) cur_axis = data[1:0];
        else cur_plane = data;
    endtask

    // drop valid, wait for drain plus the block's worst-case work time, then configure
    task automatic set_plane(logic [1:0] ax, logic [31:0] pos);
        i_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (3000) @(posedge i_clk);
        apb_write(REG_PLANE_AXIS, {30'd0, ax});
        apb_write(REG_PLANE_POS, pos);
    endtask

    function automatic logic [31:0] rnd_coord(logic signed [31:0] plane);
        case ($urandom_range(5))
            0: return plane;
            1: return $urandom;
            2: return plane + $signed($urandom_range(0, 4096)) - 2048;
            default: return plane + $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
        endcase
    endfunction

    function automatic t_vtx rnd_vertex();
        t_vtx v;
        v.px = rnd_coord(cur_plane); v.py = rnd_coord(cur_plane);
        v.pz = rnd_coord(cur_plane);
        if ($urandom_range(7) == 0) begin
            v.px = $urandom; v.py = $urandom; v.pz = $urandom;
        end
        v.cr = 16'($urandom); v.cg = 16'($urandom);
        v.cb = 16'($urandom); v.ca = 16'($urandom);
        return v;
    endfunction

    function automatic t_vtx mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [15:0] c);
        t_vtx v;
        v.px = x; v.py = y; v.pz = z;
        v.cr = c; v.cg = ~c; v.cb = c ^ 16'h5A5A; v.ca = 16'hFFFF - c / 2;
        return v;
    endfunction

    // check each accepted point item against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            point_t e;
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point x=%h", $time, o_out_x);
                err_cnt++;
            end else begin
                e = pending_points.pop_front();
                if ({o_out_x, o_out_y, o_out_z} !== {e.x, e.y, e.z}) begin
                    $display("%0t: pos exp %h %h %h got %h %h %h", $time,
                             e.x, e.y, e.z, o_out_x, o_out_y, o_out_z);
                    err_cnt++;
                end
                if ({o_out_r, o_out_g, o_out_b, o_out_a} !== {e.r, e.g, e.b, e.a}) begin
                    $display("%0t: col exp %h %h %h %h got %h %h %h %h", $time,
                             e.r, e.g, e.b, e.a, o_out_r, o_out_g, o_out_b, o_out_a);
                    err_cnt++;
                end
                if (o_point_index !== e.idx) begin
                    $display("%0t: index exp %h got %h", $time, e.idx, o_point_index);
                    err_cnt++;
                end
                if (o_last !== e.lst || o_outline_triangle !== e.outl) begin
                    $display("%0t: last/outline exp %b%b got %b%b", $time,
                             e.lst, e.outl, o_last, o_outline_triangle);
                    err_cnt++;
                end
            end
        end
    end

    // drive receiver stall
    always @(posedge i_clk) begin
        i_stall <= hold_recv || (recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    task automatic test_directed();
        logic [31:0] mx = 32'h7FFF_FFFF, mn = 32'h8000_0000;
        set_plane(AXIS_X, 32'h0001_0000);
        // all on plane: outline
        send_vertex(mk(32'h0001_0000, mn, 32'h5, 16'h0000));
        send_vertex(mk(32'h0001_0000, mx, mn, 16'hFFFF));
        send_vertex(mk(32'h0001_0000, 32'h0, mx, 16'h8000));
        // ordinary crossing, two points
        send_vertex(mk(32'h0000_0000, 32'h1000, 32'h2000, 16'h1234));
        send_vertex(mk(32'h0002_0000, 32'h3000, 32'h0, 16'hFFFF));
        send_vertex(mk(32'h0000_8000, mn, mx, 16'h0001));
        // vertex on plane against nonzero
        send_vertex(mk(32'h0001_0000, 32'h10, 32'h20, 16'h4444));
        send_vertex(mk(32'h0000_0000, 32'h30, 32'h40, 16'h8888));
        send_vertex(mk(32'h0003_0000, 32'h50, 32'h60, 16'hCCCC));
        // no crossing at all
        send_vertex(mk(mn, 32'h1, 32'h2, 16'h1));
        send_vertex(mk(32'h0, 32'h1, 32'h2, 16'h2));
        send_vertex(mk(32'h0, 32'h1, 32'h2, 16'h3));
        // extreme spans, axis three, extreme plane
        set_plane(2'd3, mx);
        send_vertex(mk(mx, mn, mn, 16'hFFFF));
        send_vertex(mk(mn, mx, mx, 16'h0000));
        send_vertex(mk(32'h0, mn, 32'h0, 16'hABCD));
        set_plane(AXIS_Y, mn);
        send_vertex(mk(mx, mn, mx, 16'h7777));
        send_vertex(mk(mn, mx, mn, 16'h9999));
        send_vertex(mk(mx, mx, mx, 16'hFFFF));
    endtask

    task automatic run_random(int n_tri, int si, int ri);
        send_idle = si; recv_idle = ri;
        for (int t = 0; t < n_tri; t++)
            for (int k = 0; k < 3; k++) send_vertex(rnd_vertex());
    endtask

    task automatic test_random_phases();
        set_plane(AXIS_Z, 32'hFFFF_0000);
        run_random(14, 0, 0);
        set_plane(AXIS_Y, 32'h0123_4567);
        run_random(14, 86, 0);
        set_plane(AXIS_X, $urandom);
        run_random(14, 0, 86);
        set_plane(AXIS_Z, 32'h0);
        run_random(14, 27, 27);
        send_idle = 0; recv_idle = 0;
    endtask

    // hold off the receiver while vertices keep coming
    task automatic test_backpressure();
        set_plane(AXIS_X, 32'h0);
        fork
            begin
                hold_recv = 1;
                repeat (4000) @(posedge i_clk);
                hold_recv = 0;
            end
            run_random(6, 0, 0);
        join
        i_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        wait (pending_points.size() == 0);
        repeat (3000) @(posedge i_clk);
        if (err_cnt == 0 && pending_points.size() == 0)
            $display("[triangle_axis_plane_slicer_top] OK");
        else
            $display("[triangle_axis_plane_slicer_top] ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("[triangle_axis_plane_slicer_top] ERROR");
        $finish;
    end
endmodule
